// ----- hdl/dock_approach_steering_top_assert.svh -----
// assertion macros for the dock approach steering block
`ifndef DOCK_APPROACH_STEERING_TOP_ASSERT_SVH
`define DOCK_APPROACH_STEERING_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DAST_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dock approach steering check failed");

// next-cycle implication, checked out of reset
`define DAST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dock approach steering check failed");

`endif

// ----- hdl/dast_pkg.sv -----
// shared types, constants and tables for the dock approach steering block
`default_nettype none

package dast_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);
    localparam int CW           = 52;
    localparam int ZW           = 20;
    localparam int AW           = 19;
    localparam int XMW          = 42;
    localparam int DW           = 27;
    localparam int LW           = 26;
    localparam int REG_W        = 17;
    localparam int OUT_W        = 18;

    localparam logic signed [ZW-1:0] PI_Q16      = 20'sd205887;
    localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [ZW-1:0] TWO_PI_P1   = 20'sd411775;
    localparam logic [15:0] GAIN_INV  = 16'd39797;
    localparam logic [14:0] K_BEARING = 15'd13107;
    localparam logic [13:0] K_DIST    = 14'd9830;
    localparam logic [24:0] Y_NEAR    = 25'd131;
    localparam logic signed [AW-1:0] YAW_DEAD = 19'sd32;
    localparam logic signed [AW-1:0] TURN_CAP = 19'sd3277;
    localparam logic signed [23:0] X_ENTER = 24'sd328;
    localparam logic signed [23:0] X_LEAVE = 24'sd1310;
    localparam logic [DW-1:0] PUB_RANGE = 27'd131072;

    localparam logic [REG_W-1:0] RST_MAX_LIN  = 17'd6554;
    localparam logic [REG_W-1:0] RST_MIN_LIN  = 17'd655;
    localparam logic [REG_W-1:0] RST_MAX_TURN = 17'd6554;

    localparam logic [1:0] REG_MAX_LIN  = 2'd0;
    localparam logic [1:0] REG_MIN_LIN  = 2'd1;
    localparam logic [1:0] REG_MAX_TURN = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LOAD_POS,
        OP_LOAD_QUAT,
        OP_STEP,
        OP_END_POS,
        OP_END_QUAT,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_DIST,
        OP_ROUND,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [ITER_W-1:0] iter;
    } t_cmd;

    typedef struct packed {
        logic stop;
    } t_status;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            5'd0:    v = 20'sd51472;
            5'd1:    v = 20'sd30386;
            5'd2:    v = 20'sd16055;
            5'd3:    v = 20'sd8150;
            5'd4:    v = 20'sd4091;
            5'd5:    v = 20'sd2047;
            5'd6:    v = 20'sd1024;
            5'd7:    v = 20'sd512;
            5'd8:    v = 20'sd256;
            5'd9:    v = 20'sd128;
            5'd10:   v = 20'sd64;
            5'd11:   v = 20'sd32;
            5'd12:   v = 20'sd16;
            5'd13:   v = 20'sd8;
            5'd14:   v = 20'sd4;
            5'd15:   v = 20'sd2;
            5'd16:   v = 20'sd1;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/dast_datapath.sv -----
// datapath: shared vectoring cordic, distance and gain products, steering decision
`default_nettype none

module dast_datapath (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  dast_pkg::t_cmd               i_cmd,
    output dast_pkg::t_status            o_status,
    input  wire                          i_action,
    input  wire  signed [23:0]           i_target_x,
    input  wire  signed [23:0]           i_target_y,
    input  wire  signed [15:0]           i_quat_x,
    input  wire  signed [15:0]           i_quat_y,
    input  wire  signed [15:0]           i_quat_z,
    input  wire  signed [15:0]           i_quat_w,
    input  wire  [dast_pkg::REG_W-1:0]   i_max_lin,
    input  wire  [dast_pkg::REG_W-1:0]   i_min_lin,
    input  wire  [dast_pkg::REG_W-1:0]   i_max_turn,
    output logic signed [dast_pkg::OUT_W-1:0] o_linear_cmd,
    output logic signed [dast_pkg::OUT_W-1:0] o_angular_cmd,
    output logic                         o_publish,
    output logic                         o_in_turning
);

    localparam int CW  = dast_pkg::CW;
    localparam int ZW  = dast_pkg::ZW;
    localparam int AW  = dast_pkg::AW;
    localparam int XMW = dast_pkg::XMW;
    localparam int DW  = dast_pkg::DW;
    localparam int LW  = dast_pkg::LW;

    logic                 r_action;
    logic signed [23:0]   r_px, r_py;
    logic signed [15:0]   r_qx, r_qy, r_qz, r_qw;
    logic signed [33:0]   r_m00, r_m10;
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0] r_cz;
    logic                 r_czero;
    logic signed [AW-1:0] r_bearing, r_yaw;
    logic [XMW-1:0]       r_xm;
    logic [36:0]          r_prod_lo, r_prod_hi;
    logic [DW-1:0]        r_dist;
    logic [LW-1:0]        r_lin_r;
    logic signed [AW-1:0] r_ang_r;
    logic                 r_turning;

    // cordic load with quadrant pre-rotation
    logic signed [CW-1:0] ld_x, ld_y, n_cx, n_cy;
    logic signed [ZW-1:0] n_cz;

    always_comb begin
        if (i_cmd.op == dast_pkg::OP_LOAD_QUAT) begin
            ld_x = {{(CW-50){r_m00[33]}}, r_m00, 16'b0};
            ld_y = {{(CW-50){r_m10[33]}}, r_m10, 16'b0};
        end else begin
            ld_x = {{(CW-40){r_px[23]}}, r_px, 16'b0};
            ld_y = {{(CW-40){r_py[23]}}, r_py, 16'b0};
        end
        if (ld_x < 0) begin
            if (ld_y >= 0) begin
                n_cx = ld_y;
                n_cy = -ld_x;
                n_cz = dast_pkg::HALF_PI_Q16;
            end else begin
                n_cx = -ld_y;
                n_cy = ld_x;
                n_cz = -dast_pkg::HALF_PI_Q16;
            end
        end else begin
            n_cx = ld_x;
            n_cy = ld_y;
            n_cz = '0;
        end
    end

    // one micro-rotation
    logic signed [CW-1:0] sh_x, sh_y;
    logic signed [ZW-1:0] at;

    always_comb begin
        sh_x = r_cx >>> i_cmd.iter;
        sh_y = r_cy >>> i_cmd.iter;
        at   = dast_pkg::atan_entry(5'(i_cmd.iter));
    end

    // wrap into (-pi, pi], zero vector reads as zero
    logic signed [ZW-1:0] z_wrap;
    logic signed [AW-1:0] ang_fin;

    always_comb begin
        if (r_cz > dast_pkg::PI_Q16) begin
            z_wrap = r_cz - dast_pkg::TWO_PI_P1;
        end else if (r_cz <= -dast_pkg::PI_Q16) begin
            z_wrap = r_cz + dast_pkg::TWO_PI_P1;
        end else begin
            z_wrap = r_cz;
        end
        ang_fin = r_czero ? '0 : z_wrap[AW-1:0];
    end

    // quaternion yaw vector
    logic signed [33:0] m00_c, m10_c;

    always_comb begin
        m00_c = 34'(r_qw * r_qw) + 34'(r_qx * r_qx) - 34'(r_qy * r_qy) - 34'(r_qz * r_qz);
        m10_c = (34'(r_qx * r_qy) + 34'(r_qw * r_qz)) <<< 1;
    end

    // distance and gain rounding
    logic [58:0]          dist_sum;
    logic [41:0]          lin_sum;
    logic signed [33:0]   ang_p;
    logic [33:0]          ang_mag;
    logic [34:0]          ang_rnd;
    logic signed [AW-1:0] ang_r_c;

    always_comb begin
        dist_sum = {r_prod_hi, 21'b0} + 59'(r_prod_lo) + (59'd1 << 31);
        lin_sum  = 42'(r_dist * dast_pkg::K_DIST) + 42'd32768;
        ang_p    = r_bearing * $signed({1'b0, dast_pkg::K_BEARING});
        ang_mag  = ang_p < 0 ? 34'(-ang_p) : 34'(ang_p);
        ang_rnd  = (35'(ang_mag) + 35'd32768) >> 16;
        ang_r_c  = ang_p < 0 ? -$signed(ang_rnd[AW-1:0]) : $signed(ang_rnd[AW-1:0]);
    end

    // steering decision
    logic signed [AW-1:0] maxa, a_c;
    logic [LW-1:0]        l_c;
    logic [24:0]          ymag;
    logic                 pub_c, mode_c;

    always_comb begin
        maxa   = $signed({2'b0, i_max_turn});
        a_c    = '0;
        l_c    = '0;
        pub_c  = 1'b1;
        mode_c = 1'b0;
        ymag   = r_py < 0 ? 25'(-$signed({r_py[23], r_py})) : 25'({r_py[23], r_py});
        if (!r_action) begin
            pub_c = r_dist < dast_pkg::PUB_RANGE;
            if (!r_turning) begin
                a_c = r_ang_r;
                if (a_c > maxa) a_c = maxa;
                if (a_c < -maxa) a_c = -maxa;
                l_c = r_lin_r;
                if (l_c > LW'(i_max_lin)) l_c = LW'(i_max_lin);
                if (l_c < LW'(i_min_lin)) l_c = LW'(i_min_lin);
                if (ymag <= dast_pkg::Y_NEAR) begin
                    if (r_yaw > dast_pkg::YAW_DEAD) begin
                        a_c = maxa;
                    end else if (r_yaw < -dast_pkg::YAW_DEAD) begin
                        a_c = -maxa;
                    end else begin
                        a_c = '0;
                    end
                end
                if (r_px < dast_pkg::X_ENTER) begin
                    l_c    = '0;
                    mode_c = 1'b1;
                end
            end else begin
                mode_c = !(r_px > dast_pkg::X_LEAVE);
                if (r_yaw > dast_pkg::YAW_DEAD) begin
                    a_c = r_yaw > dast_pkg::TURN_CAP ? dast_pkg::TURN_CAP : r_yaw;
                end else if (r_yaw < -dast_pkg::YAW_DEAD) begin
                    a_c = r_yaw < -dast_pkg::TURN_CAP ? -dast_pkg::TURN_CAP : r_yaw;
                end
            end
            if (!pub_c) begin
                l_c = '0;
                a_c = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turning <= 1'b0;
        end else if (i_cmd.op == dast_pkg::OP_FINISH) begin
            r_turning <= mode_c;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            dast_pkg::OP_ACCEPT: begin
                r_action <= i_action;
                r_px     <= i_target_x;
                r_py     <= i_target_y;
                r_qx     <= i_quat_x;
                r_qy     <= i_quat_y;
                r_qz     <= i_quat_z;
                r_qw     <= i_quat_w;
            end
            dast_pkg::OP_LOAD_POS, dast_pkg::OP_LOAD_QUAT: begin
                r_cx    <= n_cx;
                r_cy    <= n_cy;
                r_cz    <= n_cz;
                r_czero <= (ld_x == 0) && (ld_y == 0);
                if (i_cmd.op == dast_pkg::OP_LOAD_POS) begin
                    r_m00 <= m00_c;
                    r_m10 <= m10_c;
                end
            end
            dast_pkg::OP_STEP: begin
                if (r_cy >= 0) begin
                    r_cx <= r_cx + sh_y;
                    r_cy <= r_cy - sh_x;
                    r_cz <= r_cz + at;
                end else begin
                    r_cx <= r_cx - sh_y;
                    r_cy <= r_cy + sh_x;
                    r_cz <= r_cz - at;
                end
            end
            dast_pkg::OP_END_POS: begin
                r_bearing <= ang_fin;
                r_xm      <= r_cx[XMW-1:0];
            end
            dast_pkg::OP_END_QUAT: r_yaw <= ang_fin;
            dast_pkg::OP_MUL_LO: r_prod_lo <= 37'(r_xm[20:0] * dast_pkg::GAIN_INV);
            dast_pkg::OP_MUL_HI: r_prod_hi <= 37'(r_xm[XMW-1:21] * dast_pkg::GAIN_INV);
            dast_pkg::OP_DIST: r_dist <= dist_sum[58:32];
            dast_pkg::OP_ROUND: begin
                r_lin_r <= lin_sum[41:16];
                r_ang_r <= ang_r_c;
            end
            dast_pkg::OP_FINISH: begin
                o_linear_cmd  <= $signed(l_c[dast_pkg::OUT_W-1:0]);
                o_angular_cmd <= a_c[dast_pkg::OUT_W-1:0];
                o_publish     <= pub_c;
                o_in_turning  <= mode_c;
            end
            default: ;
        endcase
    end

    assign o_status.stop = r_action;

endmodule

`default_nettype wire

// ----- hdl/dast_ctrl.sv -----
// controller: sequences the cordic passes, products and result handshake
`default_nettype none

module dast_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output dast_pkg::t_cmd      o_cmd,
    input  dast_pkg::t_status   i_status
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD1, S_RUN1, S_END1, S_LOAD2, S_RUN2, S_END2,
        S_MLO, S_MHI, S_DIST, S_RND, S_FIN
    } t_state;

    localparam logic [dast_pkg::ITER_W-1:0] LAST =
        dast_pkg::ITER_W'(dast_pkg::CORDIC_STEPS - 1);

    t_state                      r_state;
    logic [dast_pkg::ITER_W-1:0] r_iter;
    logic                        accept;

    assign o_in_stall = !((r_state == S_IDLE) && (!o_out_valid || !i_out_stall));
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        o_cmd.iter = r_iter;
        unique case (r_state)
            S_IDLE:  o_cmd.op = accept ? dast_pkg::OP_ACCEPT : dast_pkg::OP_NONE;
            S_LOAD1: o_cmd.op = dast_pkg::OP_LOAD_POS;
            S_RUN1:  o_cmd.op = dast_pkg::OP_STEP;
            S_END1:  o_cmd.op = dast_pkg::OP_END_POS;
            S_LOAD2: o_cmd.op = dast_pkg::OP_LOAD_QUAT;
            S_RUN2:  o_cmd.op = dast_pkg::OP_STEP;
            S_END2:  o_cmd.op = dast_pkg::OP_END_QUAT;
            S_MLO:   o_cmd.op = dast_pkg::OP_MUL_LO;
            S_MHI:   o_cmd.op = dast_pkg::OP_MUL_HI;
            S_DIST:  o_cmd.op = dast_pkg::OP_DIST;
            S_RND:   o_cmd.op = dast_pkg::OP_ROUND;
            S_FIN:   o_cmd.op = dast_pkg::OP_FINISH;
            default: o_cmd.op = dast_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) o_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE:  if (accept) r_state <= S_LOAD1;
                S_LOAD1: begin
                    r_iter  <= '0;
                    r_state <= i_status.stop ? S_FIN : S_RUN1;
                end
                S_RUN1: begin
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == LAST) r_state <= S_END1;
                end
                S_END1:  r_state <= S_LOAD2;
                S_LOAD2: begin
                    r_iter  <= '0;
                    r_state <= S_RUN2;
                end
                S_RUN2: begin
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == LAST) r_state <= S_END2;
                end
                S_END2:  r_state <= S_MLO;
                S_MLO:   r_state <= S_MHI;
                S_MHI:   r_state <= S_DIST;
                S_DIST:  r_state <= S_RND;
                S_RND:   r_state <= S_FIN;
                S_FIN: begin
                    o_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hdl/dock_approach_steering_top.sv -----
// top level of the dock approach steering block with its register port
// A pose transaction runs from acceptance to a valid result through the single
// vectoring cordic, which runs the bearing pass and then the yaw pass one
// micro-rotation per cycle, then product, distance and rounding steps; a stop
// transaction skips to finish. The next transaction is accepted once the block
// is back in idle and the previous result is taken or leaving. Registers at
// byte addresses 0, 4 and 8: max linear speed, min linear speed, max turn rate.
`default_nettype none

module dock_approach_steering_top (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire                i_action,
    input  wire  signed [23:0] i_target_x,
    input  wire  signed [23:0] i_target_y,
    input  wire  signed [15:0] i_quat_x,
    input  wire  signed [15:0] i_quat_y,
    input  wire  signed [15:0] i_quat_z,
    input  wire  signed [15:0] i_quat_w,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic signed [17:0] o_linear_cmd,
    output logic signed [17:0] o_angular_cmd,
    output logic               o_publish,
    output logic               o_in_turning,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [3:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [dast_pkg::REG_W-1:0] r_max_lin, r_min_lin, r_max_turn;
    dast_pkg::t_cmd             cmd;
    dast_pkg::t_status          status;
    logic                       wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_lin  <= dast_pkg::RST_MAX_LIN;
            r_min_lin  <= dast_pkg::RST_MIN_LIN;
            r_max_turn <= dast_pkg::RST_MAX_TURN;
        end else if (wr) begin
            unique case (paddr[3:2])
                dast_pkg::REG_MAX_LIN:  r_max_lin  <= pwdata[dast_pkg::REG_W-1:0];
                dast_pkg::REG_MIN_LIN:  r_min_lin  <= pwdata[dast_pkg::REG_W-1:0];
                dast_pkg::REG_MAX_TURN: r_max_turn <= pwdata[dast_pkg::REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            dast_pkg::REG_MAX_LIN:  prdata = 32'(r_max_lin);
            dast_pkg::REG_MIN_LIN:  prdata = 32'(r_min_lin);
            dast_pkg::REG_MAX_TURN: prdata = 32'(r_max_turn);
            default:                prdata = '0;
        endcase
    end

    dast_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    dast_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_action      (i_action),
        .i_target_x    (i_target_x),
        .i_target_y    (i_target_y),
        .i_quat_x      (i_quat_x),
        .i_quat_y      (i_quat_y),
        .i_quat_z      (i_quat_z),
        .i_quat_w      (i_quat_w),
        .i_max_lin     (r_max_lin),
        .i_min_lin     (r_min_lin),
        .i_max_turn    (r_max_turn),
        .o_linear_cmd  (o_linear_cmd),
        .o_angular_cmd (o_angular_cmd),
        .o_publish     (o_publish),
        .o_in_turning  (o_in_turning)
    );

endmodule

`default_nettype wire

// ----- hdl/dast_checker.sv -----
// port-level checker for the dock approach steering block and its bind
`default_nettype none

`include "dock_approach_steering_top_assert.svh"

module dast_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_in_valid,
    input wire               o_in_stall,
    input wire               o_out_valid,
    input wire               i_out_stall,
    input wire signed [17:0] o_linear_cmd,
    input wire signed [17:0] o_angular_cmd,
    input wire               o_publish,
    input wire               o_in_turning
);

    `DAST_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_linear_cmd))
    `DAST_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    `DAST_ASSERT_IMP(a_no_publish_zero, o_out_valid && !o_publish, o_linear_cmd == 0 && o_angular_cmd == 0)
    `DAST_ASSERT_IMP(a_turning_no_lin, o_out_valid && o_in_turning, o_linear_cmd == 0)

endmodule

bind dock_approach_steering_top dast_checker u_dast_checker (.*);

`default_nettype wire
